FILE: hw/rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants
// Frame limits, codes, payload structs and controller/datapath interface.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_HALF    = 3;
  localparam int FRAME_CAP   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_CAP);
  localparam int DIM_W       = 7;
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);
  localparam int KW          = 3;
  localparam int SAMPLE_W    = 24;
  localparam int ACC_W       = 40;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = ACC_W + COEF_W;
  localparam int SUM_W       = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_COMPUTE = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASSES       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH    = 3'd5;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       end_of_frame;
    logic                       kind;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;
    logic          read;
    logic          rd_out;
    logic          ack;
    logic          mem_rd;
    logic          mul;
    logic          acc;
    logic          acc_first;
    logic          wr;
    logic          row_phase;
    logic          src_fs;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [KW-1:0] k;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [1:0]       m;
    logic [2:0]       passes;
  } status_t;

  // mirror about the edge sample, then clamp into [0,n-1]
  function automatic logic [XW-1:0] reflect(input logic signed [9:0] i,
                                            input logic [DIM_W-1:0] n);
    logic signed [9:0] v;
    logic signed [9:0] nn;
    v  = i;
    nn = {3'b000, n};
    if (v < 0) v = -v;
    if (v >= nn) v = 10'(2 * nn - 2 - v);
    if (v < 0) v = '0;
    if (v >= nn) v = nn - 10'sd1;
    return v[XW-1:0];
  endfunction

endpackage

FILE: hw/rtl/scr_ctrl.sv
// ----------------------------------------------------------------------------
// scr_ctrl: sequencing state machine
// Walks passes, rows, columns and taps; drives the datapath commands.
// ----------------------------------------------------------------------------
module scr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  scr_pkg::status_t status,
  output scr_pkg::cmd_t    cmd
);
  import scr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_WAIT, S_T_RD, S_T_MUL, S_T_ACC, S_T_WR, S_DONE
  } state_t;

  state_t        state;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [KW-1:0] k;
  logic [2:0]    p;
  logic          row_phase;
  logic          src_fs;
  logic          accept;
  logic          wants_out;
  logic [KW-1:0] k_last;
  logic          x_last;

  assign wants_out = (in_func == FUNC_COMPUTE) || (in_func == FUNC_READ);
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall && wants_out);
  assign accept    = in_valid && !in_stall;
  assign k_last    = KW'({status.m, 1'b0});
  assign x_last    = (DIM_W'(x) == status.w - DIM_W'(1));

  always_comb begin
    cmd           = '0;
    cmd.x         = x;
    cmd.y         = y;
    cmd.k         = k;
    cmd.row_phase = row_phase;
    cmd.src_fs    = src_fs;
    cmd.load      = (state == S_IDLE) && accept && (in_func == FUNC_LOAD);
    cmd.read      = (state == S_IDLE) && accept && (in_func == FUNC_READ);
    cmd.rd_out    = (state == S_RD_WAIT);
    cmd.ack       = (state == S_DONE);
    cmd.mem_rd    = (state == S_T_RD);
    cmd.mul       = (state == S_T_MUL);
    cmd.acc       = (state == S_T_ACC);
    cmd.acc_first = (k == '0);
    cmd.wr        = (state == S_T_WR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      x         <= '0;
      y         <= '0;
      k         <= '0;
      p         <= '0;
      row_phase <= 1'b0;
      src_fs    <= 1'b1;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && in_func == FUNC_COMPUTE) begin
            x <= '0; y <= '0; k <= '0; p <= '0;
            row_phase <= 1'b0;
            src_fs    <= 1'b1;
            state     <= S_T_RD;
          end else if (accept && in_func == FUNC_READ) begin
            state <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_T_RD:  state <= S_T_MUL;
        S_T_MUL: state <= S_T_ACC;
        S_T_ACC: begin
          if (k == k_last) begin
            state <= S_T_WR;
          end else begin
            k     <= k + KW'(1);
            state <= S_T_RD;
          end
        end
        S_T_WR: begin
          k     <= '0;
          state <= S_T_RD;
          if (x_last) begin
            x <= '0;
            if (!row_phase) begin
              row_phase <= 1'b1;
            end else begin
              row_phase <= 1'b0;
              if (DIM_W'(y) == status.h - DIM_W'(1)) begin
                y      <= '0;
                src_fs <= !src_fs;
                p      <= p + 3'd1;
                if (p + 3'd1 >= status.passes) state <= S_DONE;
              end else begin
                y <= y + YW'(1);
              end
            end
          end else begin
            x <= x + XW'(1);
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/scr_datapath.sv
// ----------------------------------------------------------------------------
// scr_datapath: buffers, MAC and config registers
// Two frame buffers, one row of column sums, a 16x40 MAC and I/O pointers.
// ----------------------------------------------------------------------------
module scr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scr_pkg::CFG_W-1:0]     cfg_data,
  input  logic signed [scr_pkg::SAMPLE_W-1:0] sample,
  input  scr_pkg::cmd_t                 cmd,
  output scr_pkg::status_t              status,
  output scr_pkg::out_t                 out_data
);
  import scr_pkg::*;

  logic [1:0]        half_width;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [2:0]        passes;
  logic [63:0]       coef_low;
  logic [47:0]       coef_high;

  logic signed [SAMPLE_W-1:0] frame_store [FRAME_CAP];
  logic signed [SAMPLE_W-1:0] pass_buffer [FRAME_CAP];
  logic signed [ACC_W-1:0]    row_acc     [MAX_WIDTH];

  logic [ADDR_W-1:0] load_ptr, read_ptr;
  logic              res_fs;
  logic              eof_q;

  logic signed [SAMPLE_W-1:0] fs_q, pb_q;
  logic signed [ACC_W-1:0]    ra_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    acc;

  logic [DIM_W-1:0]   w, h;
  logic [ADDR_W:0]    total;
  logic [ADDR_W-1:0]  lp_fix, rp_fix, lp_inc, rp_inc;
  logic [XW-1:0]      r_col, r_row;
  logic [ADDR_W-1:0]  src_addr, dst_addr, rd_addr;
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  col_val;
  logic signed [SAMPLE_W-1:0] row_val;
  logic                fs_we, pb_we;
  logic [ADDR_W-1:0]   fs_waddr;
  logic signed [SAMPLE_W-1:0] fs_wdata;

  assign w = (frame_width == '0) ? DIM_W'(1) :
             (frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
  assign h = (frame_height == '0) ? DIM_W'(1) :
             (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
  assign total = (ADDR_W+1)'(w * h);

  assign status.w      = w;
  assign status.h      = h;
  assign status.m      = half_width;
  assign status.passes = (passes == '0) ? 3'd1 : passes;

  assign lp_fix = ({1'b0, load_ptr} >= total) ? '0 : load_ptr;
  assign rp_fix = ({1'b0, read_ptr} >= total) ? '0 : read_ptr;
  assign lp_inc = ({1'b0, lp_fix} + 1'b1 >= total) ? '0 : lp_fix + ADDR_W'(1);
  assign rp_inc = ({1'b0, rp_fix} + 1'b1 >= total) ? '0 : rp_fix + ADDR_W'(1);

  // mirrored source row (column pass) and source column (row pass)
  assign r_col = reflect(10'($signed({1'b0, cmd.y})) - 10'($signed({1'b0, half_width}))
                         + 10'($signed({1'b0, cmd.k})), h);
  assign r_row = reflect(10'($signed({1'b0, cmd.x})) - 10'($signed({1'b0, half_width}))
                         + 10'($signed({1'b0, cmd.k})), w);
  assign src_addr = ADDR_W'(r_col * w) + ADDR_W'(cmd.x);
  assign dst_addr = ADDR_W'(cmd.y * w) + ADDR_W'(cmd.x);
  assign rd_addr  = cmd.read ? rp_fix : src_addr;

  always_comb begin
    case (cmd.k)
      3'd0:    coef = coef_low[15:0];
      3'd1:    coef = coef_low[31:16];
      3'd2:    coef = coef_low[47:32];
      3'd3:    coef = coef_low[63:48];
      3'd4:    coef = coef_high[15:0];
      3'd5:    coef = coef_high[31:16];
      3'd6:    coef = coef_high[47:32];
      default: coef = '0;
    endcase
  end

  assign mul_a = cmd.row_phase ? ra_q : ACC_W'(cmd.src_fs ? fs_q : pb_q);

  // round off 14 fraction bits, floor shift
  assign rnd = (acc + SUM_W'(8192)) >>> 14;
  always_comb begin
    if (rnd > SUM_W'(64'sh7F_FFFF_FFFF))        col_val = 40'sh7F_FFFF_FFFF;
    else if (rnd < -SUM_W'(64'sh80_0000_0000))  col_val = -40'sh80_0000_0000;
    else                                        col_val = rnd[ACC_W-1:0];
    if (rnd > SUM_W'(64'sh7F_FFFF))             row_val = 24'sh7F_FFFF;
    else if (rnd < -SUM_W'(64'sh80_0000))       row_val = -24'sh80_0000;
    else                                        row_val = rnd[SAMPLE_W-1:0];
  end

  assign fs_we    = cmd.load || (cmd.wr && cmd.row_phase && !cmd.src_fs);
  assign pb_we    = cmd.wr && cmd.row_phase && cmd.src_fs;
  assign fs_waddr = cmd.load ? lp_fix : dst_addr;
  assign fs_wdata = cmd.load ? sample : row_val;

  always_ff @(posedge clk) begin
    if (fs_we) frame_store[fs_waddr] <= fs_wdata;
    if (pb_we) pass_buffer[dst_addr] <= row_val;
    if (cmd.wr && !cmd.row_phase) row_acc[cmd.x] <= col_val;
    if (cmd.mem_rd || cmd.read) begin
      fs_q <= frame_store[rd_addr];
      pb_q <= pass_buffer[rd_addr];
    end
    if (cmd.mem_rd) ra_q <= row_acc[r_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= coef * mul_a;
    if (cmd.acc) acc <= (cmd.acc_first ? '0 : acc) + SUM_W'(prod);
    if (cmd.read) eof_q <= ({1'b0, rp_fix} == total - 1'b1);
    if (cmd.rd_out) begin
      out_data.value        <= res_fs ? fs_q : pb_q;
      out_data.end_of_frame <= eof_q;
      out_data.kind         <= 1'b0;
    end else if (cmd.ack) begin
      out_data.value        <= '0;
      out_data.end_of_frame <= 1'b0;
      out_data.kind         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= 2'd1;
      frame_width  <= DIM_W'(64);
      frame_height <= DIM_W'(64);
      passes       <= 3'd1;
      coef_low     <= '0;
      coef_high    <= '0;
      load_ptr     <= '0;
      read_ptr     <= '0;
      res_fs       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_HALF_WIDTH:   half_width   <= cfg_data[1:0];
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
          REG_PASSES:       passes       <= cfg_data[2:0];
          REG_COEF_LOW:     coef_low     <= cfg_data;
          REG_COEF_HIGH:    coef_high    <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (cmd.load) load_ptr <= lp_inc;
      if (cmd.read) read_ptr <= rp_inc;
      if (cmd.ack) begin
        load_ptr <= '0;
        read_ptr <= '0;
        res_fs   <= cmd.src_fs;
      end
    end
  end

endmodule

FILE: hw/rtl/separable_conv2d_reflect.sv
// ----------------------------------------------------------------------------
// separable_conv2d_reflect: separable 2D convolution, mirrored edges
// Loads a frame, filters columns then rows for N passes, streams it out.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  in      | in_valid  | in_stall  | in_data  (func, sample)
//  out     | out_valid | out_stall | out_data (value, end_of_frame, kind)
//  cfg     | cfg_wr_en | -         | cfg_index, cfg_data
//
// Load: one sample per transaction, back to back while idle. Read:
// registered memory read, then output register. Compute: each tap goes
// read -> multiply -> accumulate through one MAC, for each pass and row.
// Loads are taken while a result waits in the output register; compute
// and read wait for it to drain. Synchronous reset clears pointers and
// control and sets config registers to defaults; buffers are not cleared.
module separable_conv2d_reflect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  scr_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scr_pkg::out_t                 out_data,
  input  logic                          cfg_wr_en,
  input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scr_pkg::CFG_W-1:0]     cfg_data
);
  import scr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: loops over passes, rows, columns, taps
  scr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // buffers, MAC, pointers, config
  scr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_data.sample),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/scr_checker.sv
// ----------------------------------------------------------------------------
// scr_checker: port-level checks
// Output hold, reset, acknowledgement format, loads yield no result.
// ----------------------------------------------------------------------------
module scr_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input scr_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input scr_pkg::out_t out_data
);
  import scr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_ack_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind |-> out_data.value == '0 && !out_data.end_of_frame)
    else $error("malformed acknowledgement");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.func == FUNC_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a result");

endmodule

bind separable_conv2d_reflect scr_checker u_scr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
